FILE: design/key_macro_playback_sequencer_defines.svh
// Assertion macros shared by the key macro playback sequencer.
`ifndef KEY_MACRO_PLAYBACK_SEQUENCER_DEFINES_SVH
`define KEY_MACRO_PLAYBACK_SEQUENCER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define KMPS_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("key macro sequencer check failed");

// Next-cycle implication, checked outside reset.
`define KMPS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("key macro sequencer check failed");

`else

`define KMPS_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define KMPS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

FILE: design/kmps_pkg.sv
// Shared types, codes and helpers of the key macro playback sequencer.
package kmps_pkg;

    localparam int KEY_COUNT_DEF        = 256;
    localparam int KEY_QUEUE_DEPTH_DEF  = 256;
    localparam int STEP_QUEUE_DEPTH_DEF = 64;
    localparam int CMD_QUEUE_DEPTH      = 2;

    localparam int KEY_W    = 8;
    localparam int FRAME_W  = 16;
    localparam int MS_W     = 32;
    localparam int OP_W     = 3;
    localparam int STATUS_W = 2;
    localparam int PHASE_W  = 2;

    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 8;

    typedef logic [OP_W-1:0]     op_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [PHASE_W-1:0]  phase_t;

    localparam op_t OP_ENQUEUE = 3'd0;
    localparam op_t OP_FRAME   = 3'd1;
    localparam op_t OP_COMMIT  = 3'd2;
    localparam op_t OP_MS_TICK = 3'd3;
    localparam op_t OP_QUERY   = 3'd4;

    localparam status_t STATUS_OK      = 2'd0;
    localparam status_t STATUS_DONE    = 2'd1;
    localparam status_t STATUS_TIMEOUT = 2'd2;
    localparam status_t STATUS_DROPPED = 2'd3;

    localparam phase_t PH_IDLE = 2'd0;
    localparam phase_t PH_HOLD = 2'd1;
    localparam phase_t PH_GAP  = 2'd2;

    // One classified input word as it waits for the playback engine.
    typedef struct packed {
        op_t                op;
        logic [KEY_W-1:0]   key;
        logic               key_ok;
        logic               last;
        logic [FRAME_W-1:0] hold;
        logic [FRAME_W-1:0] gap;
        logic [MS_W-1:0]    tmo;
        logic               tmo_zero;
    } cmd_t;

    // Key zero and codes at or above the key count are never pressed.
    function automatic logic key_is_valid(input logic [KEY_W-1:0] k, input int unsigned kc);
        return (k != '0) && (32'(k) < kc);
    endfunction

endpackage

FILE: design/kmps_front.sv
// Input side: accepts words from the stream and classifies them into commands.
module kmps_front
    import kmps_pkg::*;
#(
    parameter int KEY_COUNT = KEY_COUNT_DEF
) (
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // key[7:0], hold_frames[23:8], gap_frames[39:24],
                                           // timeout_ms[71:40]
    input  logic [OP_W-1:0]     s_tuser,   // operation[2:0]
    input  logic                s_tlast,   // end_of_step
    input  logic                fifo_full,
    output logic                push,
    output cmd_t                cmd
);

    assign s_tready = !fifo_full;
    assign push     = s_tvalid && !fifo_full;

    always_comb begin
        cmd.op       = s_tuser;
        cmd.key      = s_tdata[7:0];
        cmd.last     = s_tlast;
        cmd.hold     = s_tdata[23:8];
        cmd.gap      = s_tdata[39:24];
        cmd.tmo      = s_tdata[71:40];
        cmd.key_ok   = key_is_valid(s_tdata[7:0], KEY_COUNT);
        cmd.tmo_zero = (s_tdata[71:40] == '0);
    end

endmodule

FILE: design/kmps_cmd_fifo.sv
// Short command queue between the input side and the playback engine.
module kmps_cmd_fifo
    import kmps_pkg::*;
#(
    parameter int DEPTH = CMD_QUEUE_DEPTH
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_data,
    output logic full,
    input  logic pop,
    output logic empty,
    output cmd_t pop_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: design/kmps_back.sv
// Playback engine: key and step queues, down bitmap, timers and the result register.
module kmps_back
    import kmps_pkg::*;
#(
    parameter int KEY_COUNT        = KEY_COUNT_DEF,
    parameter int KEY_QUEUE_DEPTH  = KEY_QUEUE_DEPTH_DEF,
    parameter int STEP_QUEUE_DEPTH = STEP_QUEUE_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cmd_valid,
    input  cmd_t                cmd,
    output logic                cmd_pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata
);

    localparam int KIW   = $clog2(KEY_COUNT);
    localparam int KQ_AW = $clog2(KEY_QUEUE_DEPTH);
    localparam int KQ_CW = $clog2(KEY_QUEUE_DEPTH + 1);
    localparam int SQ_AW = $clog2(STEP_QUEUE_DEPTH);
    localparam int SQ_CW = $clog2(STEP_QUEUE_DEPTH + 1);

    localparam logic BS_DISPATCH = 1'b0;
    localparam logic BS_WALK     = 1'b1;

    logic [KEY_W:0]       kq_mem [KEY_QUEUE_DEPTH];
    logic [2*FRAME_W-1:0] sq_mem [STEP_QUEUE_DEPTH];
    logic [KEY_W:0]       kq_rdata_reg;
    logic [2*FRAME_W-1:0] sq_rdata_reg;
    logic                 kq_we, sq_we;
    logic [KQ_AW-1:0]     kq_raddr;

    logic                 state_reg, state_next;
    logic [KEY_COUNT-1:0] down_map_reg, down_map_next;
    logic [KQ_AW-1:0]     kq_head_reg, kq_head_next;
    logic [KQ_AW-1:0]     kq_tail_reg, kq_tail_next;
    logic [KQ_AW-1:0]     kq_open_reg, kq_open_next;
    logic [KQ_CW-1:0]     kq_count_reg, kq_count_next;
    logic [KQ_CW-1:0]     open_count_reg, open_count_next;
    logic                 discard_reg, discard_next;
    logic [SQ_AW-1:0]     sq_head_reg, sq_head_next;
    logic [SQ_AW-1:0]     sq_tail_reg, sq_tail_next;
    logic [SQ_CW-1:0]     sq_count_reg, sq_count_next;
    phase_t               phase_reg, phase_next;
    logic [FRAME_W-1:0]   frames_reg, frames_next;
    logic                 busy_reg, busy_next;
    logic [MS_W-1:0]      ms_reg, ms_next;
    logic [KQ_AW-1:0]     walk_ptr_reg, walk_ptr_next;
    logic [KQ_CW-1:0]     walk_cnt_reg, walk_cnt_next;
    logic                 walk_val_reg, walk_val_next;
    logic                 out_valid_reg, out_valid_next;
    logic [M_DATA_W-1:0]  out_data_reg, out_data_next;

    logic                 out_free;
    logic                 emit;
    logic                 do_clear;
    logic                 start_walk;
    logic                 kd;
    status_t              status;
    logic [FRAME_W-1:0]   frames_dec;
    logic [MS_W-1:0]      ms_dec;
    logic [KQ_CW-1:0]     wc_inc;
    logic                 walk_done;

    function automatic logic [KQ_AW-1:0] kq_inc(input logic [KQ_AW-1:0] p);
        return (p == KQ_AW'(KEY_QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [SQ_AW-1:0] sq_inc(input logic [SQ_AW-1:0] p);
        return (p == SQ_AW'(STEP_QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [FRAME_W-1:0] at_least_one(input logic [FRAME_W-1:0] v);
        return (v == '0) ? FRAME_W'(1) : v;
    endfunction

    assign out_free = !out_valid_reg || m_tready;
    assign cmd_pop  = (state_reg == BS_DISPATCH) && cmd_valid && out_free;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign frames_dec = (frames_reg != '0) ? frames_reg - 1'b1 : frames_reg;
    assign ms_dec     = (ms_reg != '0) ? ms_reg - 1'b1 : ms_reg;
    assign wc_inc     = walk_cnt_reg + 1'b1;
    // A step ends at its end mark; the count bound only guards a corrupted queue.
    assign walk_done  = kq_rdata_reg[KEY_W] || (wc_inc == kq_count_reg);

    always_comb begin
        state_next      = state_reg;
        down_map_next   = down_map_reg;
        kq_head_next    = kq_head_reg;
        kq_tail_next    = kq_tail_reg;
        kq_open_next    = kq_open_reg;
        kq_count_next   = kq_count_reg;
        open_count_next = open_count_reg;
        discard_next    = discard_reg;
        sq_head_next    = sq_head_reg;
        sq_tail_next    = sq_tail_reg;
        sq_count_next   = sq_count_reg;
        phase_next      = phase_reg;
        frames_next     = frames_reg;
        busy_next       = busy_reg;
        ms_next         = ms_reg;
        walk_ptr_next   = walk_ptr_reg;
        walk_cnt_next   = walk_cnt_reg;
        walk_val_next   = walk_val_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_data_next   = out_data_reg;
        kq_we           = 1'b0;
        sq_we           = 1'b0;
        kq_raddr        = kq_head_reg;
        emit            = 1'b0;
        do_clear        = 1'b0;
        start_walk      = 1'b0;
        kd              = 1'b0;
        status          = STATUS_OK;

        unique case (state_reg)
            BS_DISPATCH: begin
                if (cmd_pop) begin
                    emit = 1'b1;
                    case (cmd.op)
                        OP_ENQUEUE: begin
                            if (discard_reg) begin
                                if (cmd.last) begin
                                    discard_next = 1'b0;
                                end
                                status = STATUS_DROPPED;
                            end else if ((cmd.last && sq_count_reg == SQ_CW'(STEP_QUEUE_DEPTH))
                                         || kq_count_reg == KQ_CW'(KEY_QUEUE_DEPTH)) begin
                                // The open step is thrown away as a whole.
                                kq_count_next   = kq_count_reg - open_count_reg;
                                kq_tail_next    = kq_open_reg;
                                open_count_next = '0;
                                discard_next    = !cmd.last;
                                status          = STATUS_DROPPED;
                            end else begin
                                kq_we         = 1'b1;
                                kq_tail_next  = kq_inc(kq_tail_reg);
                                kq_count_next = kq_count_reg + 1'b1;
                                if (cmd.last) begin
                                    sq_we           = 1'b1;
                                    sq_tail_next    = sq_inc(sq_tail_reg);
                                    sq_count_next   = sq_count_reg + 1'b1;
                                    open_count_next = '0;
                                    kq_open_next    = kq_inc(kq_tail_reg);
                                end else begin
                                    open_count_next = open_count_reg + 1'b1;
                                end
                            end
                        end
                        OP_FRAME: begin
                            if (busy_reg) begin
                                if (phase_reg == PH_HOLD && frames_dec == '0) begin
                                    start_walk    = 1'b1;
                                    walk_val_next = 1'b0;
                                end else if (phase_reg != PH_IDLE && frames_dec != '0) begin
                                    frames_next = frames_dec;
                                end else if (sq_count_reg == '0) begin
                                    phase_next  = PH_IDLE;
                                    frames_next = frames_dec;
                                    busy_next   = 1'b0;
                                    status      = STATUS_DONE;
                                end else begin
                                    start_walk    = 1'b1;
                                    walk_val_next = 1'b1;
                                end
                            end
                        end
                        OP_COMMIT: begin
                            busy_next = 1'b1;
                            ms_next   = cmd.tmo;
                            if (cmd.tmo_zero) begin
                                do_clear = 1'b1;
                                status   = STATUS_TIMEOUT;
                            end
                        end
                        OP_MS_TICK: begin
                            if (busy_reg) begin
                                ms_next = ms_dec;
                                if (ms_dec == '0) begin
                                    do_clear = 1'b1;
                                    status   = STATUS_TIMEOUT;
                                end
                            end
                        end
                        OP_QUERY: begin
                            kd = cmd.key_ok ? down_map_reg[cmd.key[KIW-1:0]] : 1'b0;
                        end
                        default: begin
                        end
                    endcase
                    if (start_walk) begin
                        // The head entry is read this cycle and applied in the next.
                        emit          = 1'b0;
                        state_next    = BS_WALK;
                        walk_ptr_next = kq_head_reg;
                        walk_cnt_next = '0;
                    end
                end
            end
            BS_WALK: begin
                if (key_is_valid(kq_rdata_reg[KEY_W-1:0], KEY_COUNT)) begin
                    down_map_next[kq_rdata_reg[KIW-1:0]] = walk_val_reg;
                end
                if (!walk_done) begin
                    walk_ptr_next = kq_inc(walk_ptr_reg);
                    walk_cnt_next = wc_inc;
                    kq_raddr      = kq_inc(walk_ptr_reg);
                end else begin
                    state_next = BS_DISPATCH;
                    emit       = 1'b1;
                    if (walk_val_reg) begin
                        phase_next  = PH_HOLD;
                        frames_next = at_least_one(sq_rdata_reg[2*FRAME_W-1:FRAME_W]);
                    end else begin
                        // The released step leaves the head of both queues.
                        kq_head_next  = kq_inc(walk_ptr_reg);
                        kq_count_next = kq_count_reg - wc_inc;
                        sq_head_next  = sq_inc(sq_head_reg);
                        sq_count_next = sq_count_reg - 1'b1;
                        phase_next    = PH_GAP;
                        frames_next   = at_least_one(sq_rdata_reg[FRAME_W-1:0]);
                    end
                end
            end
            default: begin
                state_next = BS_DISPATCH;
            end
        endcase

        if (do_clear) begin
            down_map_next   = '0;
            kq_head_next    = '0;
            kq_tail_next    = '0;
            kq_open_next    = '0;
            kq_count_next   = '0;
            open_count_next = '0;
            discard_next    = 1'b0;
            sq_head_next    = '0;
            sq_tail_next    = '0;
            sq_count_next   = '0;
            phase_next      = PH_IDLE;
            frames_next     = '0;
            busy_next       = 1'b0;
            ms_next         = '0;
        end

        if (emit) begin
            out_valid_next = 1'b1;
            out_data_next  = {2'b00, phase_next, busy_next, status, kd};
        end
    end

    always_ff @(posedge aclk) begin
        if (kq_we) begin
            kq_mem[kq_tail_reg] <= {cmd.last, cmd.key};
        end
        kq_rdata_reg <= kq_mem[kq_raddr];
    end

    always_ff @(posedge aclk) begin
        if (sq_we) begin
            sq_mem[sq_tail_reg] <= {cmd.hold, cmd.gap};
        end
        sq_rdata_reg <= sq_mem[sq_head_reg];
    end

    always_ff @(posedge aclk) begin
        walk_ptr_reg <= walk_ptr_next;
        walk_cnt_reg <= walk_cnt_next;
        walk_val_reg <= walk_val_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= BS_DISPATCH;
            down_map_reg   <= '0;
            kq_head_reg    <= '0;
            kq_tail_reg    <= '0;
            kq_open_reg    <= '0;
            kq_count_reg   <= '0;
            open_count_reg <= '0;
            discard_reg    <= 1'b0;
            sq_head_reg    <= '0;
            sq_tail_reg    <= '0;
            sq_count_reg   <= '0;
            phase_reg      <= PH_IDLE;
            frames_reg     <= '0;
            busy_reg       <= 1'b0;
            ms_reg         <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            down_map_reg   <= down_map_next;
            kq_head_reg    <= kq_head_next;
            kq_tail_reg    <= kq_tail_next;
            kq_open_reg    <= kq_open_next;
            kq_count_reg   <= kq_count_next;
            open_count_reg <= open_count_next;
            discard_reg    <= discard_next;
            sq_head_reg    <= sq_head_next;
            sq_tail_reg    <= sq_tail_next;
            sq_count_reg   <= sq_count_next;
            phase_reg      <= phase_next;
            frames_reg     <= frames_next;
            busy_reg       <= busy_next;
            ms_reg         <= ms_next;
            out_valid_reg  <= out_valid_next;
        end
    end

endmodule

FILE: design/key_macro_playback_sequencer.sv
// Top level of the key macro playback sequencer.
// Every input word produces exactly one result word. Words pass through a two-entry
// command queue into the playback engine, which takes one command per cycle when the
// result register is free and no step walk is running, so enqueue, tick, commit and
// query words sustain one word per cycle. A frame tick that presses or releases a step
// walks that step's key entries out of the key queue memory, one entry per cycle,
// before its result word is written. Reset clears the down bitmap at once; no clearing
// pass is needed.
`include "key_macro_playback_sequencer_defines.svh"

module key_macro_playback_sequencer
    import kmps_pkg::*;
#(
    parameter int KEY_COUNT        = KEY_COUNT_DEF,
    parameter int KEY_QUEUE_DEPTH  = KEY_QUEUE_DEPTH_DEF,
    parameter int STEP_QUEUE_DEPTH = STEP_QUEUE_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // key[7:0], hold_frames[23:8], gap_frames[39:24],
                                           // timeout_ms[71:40]
    input  logic [OP_W-1:0]     s_tuser,   // operation[2:0]
    input  logic                s_tlast,   // end_of_step
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // key_down[0], status[2:1], busy_res[3], phase[5:4],
                                           // zero[7:6]
);

    cmd_t push_cmd;
    cmd_t pop_cmd;
    logic fifo_push;
    logic fifo_full;
    logic fifo_empty;
    logic fifo_pop;

    kmps_front #(
        .KEY_COUNT (KEY_COUNT)
    ) u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .fifo_full (fifo_full),
        .push      (fifo_push),
        .cmd       (push_cmd)
    );

    kmps_cmd_fifo #(
        .DEPTH (CMD_QUEUE_DEPTH)
    ) u_cmd_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (fifo_push),
        .push_data (push_cmd),
        .full      (fifo_full),
        .pop       (fifo_pop),
        .empty     (fifo_empty),
        .pop_data  (pop_cmd)
    );

    kmps_back #(
        .KEY_COUNT        (KEY_COUNT),
        .KEY_QUEUE_DEPTH  (KEY_QUEUE_DEPTH),
        .STEP_QUEUE_DEPTH (STEP_QUEUE_DEPTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (!fifo_empty),
        .cmd       (pop_cmd),
        .cmd_pop   (fifo_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // A playing phase is only reported while the batch is busy.
    `KMPS_ASSERT_IMPL(a_phase_needs_busy, aclk, aresetn, m_tvalid && (m_tdata[5:4] != PH_IDLE), m_tdata[3])

    // Completion and abort both leave the player idle and not busy.
    `KMPS_ASSERT_IMPL(a_end_is_idle, aclk, aresetn, m_tvalid && (m_tdata[2:1] == STATUS_DONE || m_tdata[2:1] == STATUS_TIMEOUT), !m_tdata[3] && (m_tdata[5:4] == PH_IDLE))

    // Only a query reports a held key, and a query always succeeds.
    `KMPS_ASSERT_IMPL(a_key_down_ok, aclk, aresetn, m_tvalid && m_tdata[0], m_tdata[2:1] == STATUS_OK)

    // A command taken from a full queue frees a slot for the input side.
    `KMPS_ASSERT_NEXT(a_pop_frees_input, aclk, aresetn, fifo_pop && fifo_full, s_tready)

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for the key macro playback sequencer.
module testbench
    import kmps_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int KQ_DEPTH   = KEY_QUEUE_DEPTH_DEF;
    localparam int SQ_DEPTH   = STEP_QUEUE_DEPTH_DEF;
    localparam int IDLE_LIMIT = 5000;
    localparam int RANDOM_WORDS = 650;

    // One result word, laid out as on m_tdata[5:0].
    typedef struct packed {
        phase_t  ph;
        logic    busy;
        status_t st;
        logic    kd;
    } report_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic [OP_W-1:0]     s_tuser = '0;
    logic                s_tlast = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    key_macro_playback_sequencer i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Shadow copy of the sequencer state.
    bit          key_held [256];
    logic [8:0]  key_fifo [KQ_DEPTH];
    logic [31:0] step_fifo [SQ_DEPTH];
    int unsigned kf_head, kf_count, open_entries, sf_head, sf_count;
    bit          dropping_step;
    phase_t      play_ph;
    int unsigned frames_rem;
    bit          batch_busy;
    logic [31:0] ms_rem;

    report_t     owed_reports [$];
    int unsigned idle_pct, stall_pct;
    int unsigned words_sent, words_checked, err_cnt;
    int unsigned done_cnt, abort_cnt, drop_cnt;
    int unsigned quiet_cycles;
    int unsigned idle_by_phase  [4] = '{0, 70, 0, 9};
    int unsigned stall_by_phase [4] = '{0, 0, 70, 9};

    // Presses or releases the head step's keys; returns the entries it spans.
    function automatic int unsigned set_head_keys(bit value);
        logic [8:0] ent;
        for (int unsigned i = 0; i < kf_count; i++) begin
            ent = key_fifo[(kf_head + i) % KQ_DEPTH];
            if (ent[7:0] != 8'd0) key_held[ent[7:0]] = value;
            if (ent[8]) return i + 1;
        end
        return kf_count;
    endfunction

    function automatic void abort_batch();
        foreach (key_held[k]) key_held[k] = 1'b0;
        kf_head = 0;
        kf_count = 0;
        open_entries = 0;
        sf_head = 0;
        sf_count = 0;
        dropping_step = 1'b0;
        play_ph = PH_IDLE;
        frames_rem = 0;
        batch_busy = 1'b0;
        ms_rem = '0;
    endfunction

    function automatic status_t start_step();
        logic [15:0] hold;
        if (sf_count == 0) begin
            play_ph = PH_IDLE;
            batch_busy = 1'b0;
            return STATUS_DONE;
        end
        void'(set_head_keys(1'b1));
        hold = step_fifo[sf_head][31:16];
        play_ph = PH_HOLD;
        frames_rem = (hold != 16'd0) ? hold : 1;
        return STATUS_OK;
    endfunction

    // Advances the shadow state by one accepted word and returns its report.
    function automatic report_t apply_word(op_t op, logic [7:0] key, logic last,
                                           logic [15:0] hold, logic [15:0] gap,
                                           logic [31:0] tmo);
        report_t     rep;
        int unsigned n;
        logic [15:0] gap_len;
        rep = '0;
        case (op)
            OP_ENQUEUE: begin
                if (dropping_step) begin
                    if (last) dropping_step = 1'b0;
                    rep.st = STATUS_DROPPED;
                end else if ((last && sf_count >= SQ_DEPTH) || kf_count >= KQ_DEPTH) begin
                    kf_count -= open_entries;
                    open_entries = 0;
                    if (!last) dropping_step = 1'b1;
                    rep.st = STATUS_DROPPED;
                end else begin
                    key_fifo[(kf_head + kf_count) % KQ_DEPTH] = {last, key};
                    kf_count++;
                    if (last) begin
                        step_fifo[(sf_head + sf_count) % SQ_DEPTH] = {hold, gap};
                        sf_count++;
                        open_entries = 0;
                    end else begin
                        open_entries++;
                    end
                end
            end
            OP_FRAME: begin
                if (batch_busy) begin
                    if (play_ph == PH_IDLE) begin
                        rep.st = start_step();
                    end else begin
                        if (frames_rem > 0) frames_rem--;
                        if (frames_rem == 0) begin
                            if (play_ph == PH_HOLD) begin
                                n = set_head_keys(1'b0);
                                kf_head = (kf_head + n) % KQ_DEPTH;
                                kf_count -= n;
                                gap_len = step_fifo[sf_head][15:0];
                                sf_head = (sf_head + 1) % SQ_DEPTH;
                                sf_count--;
                                play_ph = PH_GAP;
                                frames_rem = (gap_len != 16'd0) ? gap_len : 1;
                            end else begin
                                rep.st = start_step();
                            end
                        end
                    end
                end
            end
            OP_COMMIT: begin
                batch_busy = 1'b1;
                ms_rem = tmo;
                if (tmo == 32'd0) begin
                    abort_batch();
                    rep.st = STATUS_TIMEOUT;
                end
            end
            OP_MS_TICK: begin
                if (batch_busy) begin
                    if (ms_rem != 32'd0) ms_rem--;
                    if (ms_rem == 32'd0) begin
                        abort_batch();
                        rep.st = STATUS_TIMEOUT;
                    end
                end
            end
            OP_QUERY: begin
                rep.kd = (key != 8'd0) && key_held[key];
            end
            default: begin
            end
        endcase
        rep.busy = batch_busy;
        rep.ph = play_ph;
        return rep;
    endfunction

    function automatic void flag_error(string what);
        err_cnt++;
        if (err_cnt <= 10) $display("ERROR at %0t: %s", $realtime, what);
    endfunction

    // Valid stays high between back-to-back words; it only drops while idling or draining.
    task automatic send_word(op_t op, logic [7:0] key, logic last, logic [15:0] hold,
                             logic [15:0] gap, logic [31:0] tmo);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tlast  <= last;
        s_tdata  <= {tmo, gap, hold, key};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        owed_reports.push_back(apply_word(op, key, last, hold, gap, tmo));
        words_sent++;
    endtask

    task automatic enqueue_key(logic [7:0] k, logic last, logic [15:0] hold, logic [15:0] gap);
        send_word(OP_ENQUEUE, k, last, hold, gap, $urandom);
    endtask

    task automatic frame_tick();
        send_word(OP_FRAME, 8'($urandom), 1'($urandom), 16'($urandom), 16'($urandom),
                  $urandom);
    endtask

    task automatic commit_batch(logic [31:0] tmo);
        send_word(OP_COMMIT, 8'($urandom), 1'($urandom), 16'($urandom), 16'($urandom), tmo);
    endtask

    task automatic ms_tick();
        send_word(OP_MS_TICK, 8'($urandom), 1'($urandom), 16'($urandom), 16'($urandom),
                  $urandom);
    endtask

    task automatic query_key(logic [7:0] k);
        send_word(OP_QUERY, k, 1'($urandom), 16'($urandom), 16'($urandom), $urandom);
    endtask

    task automatic send_noise();
        send_word(op_t'($urandom_range(0, 4)), 8'($urandom), 1'($urandom), 16'($urandom),
                  16'($urandom), $urandom);
    endtask

    // Waits on the clock before checking, so valid is never lowered and raised in one step.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (owed_reports.size() != 0);
    endtask

    // Ticks frames until the batch finishes or the budget runs out, then aborts it.
    task automatic play_out(int unsigned max_ticks);
        for (int unsigned i = 0; i < max_ticks && batch_busy; i++) frame_tick();
        if (batch_busy) commit_batch(32'd0);
    endtask

    function automatic logic [15:0] pick_frames();
        return ($urandom_range(99) < 85) ? 16'($urandom_range(0, 3)) : 16'($urandom);
    endfunction

    task automatic test_basic_playback();
        query_key(8'd0);
        query_key(8'hFF);
        frame_tick();
        ms_tick();
        enqueue_key(8'h01, 1'b0, 16'd7, 16'd7);
        enqueue_key(8'hFF, 1'b0, 16'd9, 16'd9);
        enqueue_key(8'h00, 1'b1, 16'd0, 16'd0);
        enqueue_key(8'hAA, 1'b1, 16'd2, 16'd1);
        commit_batch(32'hFFFF_FFFF);
        frame_tick();
        query_key(8'hFF);
        query_key(8'h00);
        frame_tick();
        query_key(8'hFF);
        commit_batch(32'd5);
        frame_tick();
        frame_tick();
        query_key(8'hAA);
        frame_tick();
        frame_tick();
        query_key(8'hAA);
        // Long hold and gap, so the batch can only end through the timeout.
        enqueue_key(8'h55, 1'b1, 16'hFFFF, 16'hFFFF);
        commit_batch(32'd2);
        frame_tick();
        query_key(8'h55);
        ms_tick();
        ms_tick();
        query_key(8'h55);
        commit_batch(32'd0);
    endtask

    task automatic test_step_queue_overflow();
        for (int i = 1; i <= SQ_DEPTH; i++) enqueue_key(8'(i), 1'b1, 16'd0, 16'd0);
        // The open step is lost as a whole when its closing entry finds no room.
        enqueue_key(8'h77, 1'b0, 16'd1, 16'd1);
        enqueue_key(8'h78, 1'b1, 16'd1, 16'd1);
        commit_batch(32'h0001_0000);
        play_out(12);
        drain_results();
    endtask

    task automatic test_key_queue_overflow();
        for (int i = 0; i < KQ_DEPTH; i++) enqueue_key(8'($urandom), 1'b0, 16'd1, 16'd1);
        for (int i = 0; i < 3; i++) enqueue_key(8'($urandom), 1'b0, 16'd1, 16'd1);
        enqueue_key(8'($urandom), 1'b1, 16'd1, 16'd1);
        // A long step makes every press and release walk many entries.
        for (int i = 0; i < 200; i++) enqueue_key(8'(i), i == 199, 16'd2, 16'd1);
        commit_batch(32'hFFFF_FFFF);
        frame_tick();
        query_key(8'd150);
        query_key(8'd199);
        play_out(8);
        drain_results();
        // Key queue full: the closing entry is dropped with its open step, without discarding.
        for (int s = 0; s < SQ_DEPTH - 1; s++) begin
            for (int e = 0; e < 4; e++) enqueue_key(8'($urandom), e == 3, pick_frames(), 16'd0);
        end
        for (int e = 0; e < 4; e++) enqueue_key(8'($urandom), 1'b0, 16'd0, 16'd0);
        enqueue_key(8'($urandom), 1'b1, 16'd0, 16'd0);
        enqueue_key(8'($urandom), 1'b1, 16'd0, 16'd0);
        commit_batch(32'd3);
        frame_tick();
        ms_tick();
        frame_tick();
        ms_tick();
        ms_tick();
        drain_results();
    endtask

    task automatic random_batch();
        int unsigned n_steps, n_ents, guard, pick;
        logic [7:0]  k;
        logic [7:0]  batch_keys [$];
        n_steps = $urandom_range(1, 5);
        for (int unsigned s = 0; s < n_steps; s++) begin
            n_ents = $urandom_range(1, 4);
            for (int unsigned e = 0; e < n_ents; e++) begin
                k = 8'($urandom);
                batch_keys.push_back(k);
                enqueue_key(k, e == n_ents - 1, pick_frames(), pick_frames());
                if ($urandom_range(99) < 6) send_noise();
            end
        end
        commit_batch(($urandom_range(99) < 30) ? 32'($urandom_range(1, 24)) : 32'($urandom));
        guard = 0;
        while (batch_busy && guard < 80) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                frame_tick();
            end else if (pick < 80) begin
                if ($urandom_range(1) == 1) begin
                    k = batch_keys[$urandom_range(batch_keys.size() - 1)];
                end else begin
                    k = 8'($urandom);
                end
                query_key(k);
            end else if (pick < 93) begin
                ms_tick();
            end else begin
                send_noise();
            end
            guard++;
        end
        // Now and then a batch is left running into the next one.
        if (batch_busy && $urandom_range(99) < 85) commit_batch(32'd0);
    endtask

    task automatic test_random_batches(int unsigned n_words);
        int unsigned phase_end;
        for (int p = 0; p < 4; p++) begin
            drain_results();
            idle_pct  = idle_by_phase[p];
            stall_pct = stall_by_phase[p];
            phase_end = words_sent + n_words / 4;
            while (words_sent < phase_end) random_batch();
        end
        idle_pct  = 0;
        stall_pct = 0;
    endtask

    always @(posedge aclk) begin : check_results
        report_t want, got;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[5:0];
            words_checked++;
            if (owed_reports.size() == 0) begin
                flag_error($sformatf("result word 0x%02h with no input word pending", m_tdata));
            end else begin
                want = owed_reports[0];
                owed_reports.delete(0);
                if (got.kd !== want.kd || got.st !== want.st || got.busy !== want.busy ||
                    got.ph !== want.ph) begin
                    flag_error($sformatf(
                        "kd/st/busy/ph expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                        want.kd, want.st, want.busy, want.ph, got.kd, got.st, got.busy, got.ph));
                end
                case (want.st)
                    STATUS_DONE:    done_cnt++;
                    STATUS_TIMEOUT: abort_cnt++;
                    STATUS_DROPPED: drop_cnt++;
                    default: begin
                    end
                endcase
            end
        end
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("Stalled for %0d cycles with %0d results outstanding", IDLE_LIMIT,
                     owed_reports.size());
            $display("testbench: done, errors");
            $finish;
        end
    end

    initial begin
        idle_pct = 0;
        stall_pct = 0;
        abort_batch();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_basic_playback();
        drain_results();
        test_step_queue_overflow();
        test_key_queue_overflow();
        test_random_batches(RANDOM_WORDS);
        drain_results();
        repeat (300) @(posedge aclk);
        $display("Sent %0d words and checked %0d results, with and without idling on both sides.",
                 words_sent, words_checked);
        $display("Batches completed: %0d, aborted by timeout: %0d, entries dropped: %0d.",
                 done_cnt, abort_cnt, drop_cnt);
        if (err_cnt == 0 && owed_reports.size() == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("%0d mismatches, %0d results never arrived", err_cnt, owed_reports.size());
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+design
design/kmps_pkg.sv
design/kmps_front.sv
design/kmps_cmd_fifo.sv
design/kmps_back.sv
design/key_macro_playback_sequencer.sv
verif/testbench.sv
